/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold on every rising clock edge, off while reset is high
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, (1'b1 |-> (cond)), msg)

`endif

/* src/sdsb_pkg.sv */
// types and constants of the sorted dedup signature builder
package sdsb_pkg;

   localparam int SIG_DEPTH_DEF = 32;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   typedef struct packed {
      logic [31:0] label;
      logic [63:0] id;
   } pair_type;

   typedef struct packed {
      logic        func;
      logic [31:0] edge_label;
      logic [63:0] dest_id;
      logic [63:0] own_id;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] out_label;
      logic [63:0] out_id;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

/* src/sdsb_cell.sv */
// one cell of the sorted insertion chain
module sdsb_cell (
   input  logic                  clock,
   input  sdsb_pkg::cell_ctrl_type ctrl,
   input  logic                  valid,
   input  sdsb_pkg::pair_type    new_pair,
   input  sdsb_pkg::pair_type    left_pair,
   input  logic                  left_lt,
   input  sdsb_pkg::pair_type    right_pair,
   output sdsb_pkg::pair_type    pair,
   output logic                  lt,
   output logic                  eq
);

   sdsb_pkg::pair_type entry_ff;
   sdsb_pkg::pair_type entry_in;

   // label is the upper part of the packed pair, so one compare orders both keys
   assign lt   = valid && (entry_ff < new_pair);
   assign eq   = valid && (entry_ff == new_pair);
   assign pair = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!lt) begin
            entry_in = left_lt ? new_pair : left_pair;
         end
      end else if (ctrl.shift) begin
         entry_in = right_pair;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* src/sorted_dedup_signature_builder.sv */
// top level of the sorted dedup signature builder
//
// Builds one state's signature from (label, destination id) edge pairs. An insert beat
// (func 0) compares the pair against every cell of the chain at once: a duplicate is
// dropped, and otherwise the cells at and above the insertion point shift up by one
// neighbor while the new pair drops into place. When all SIG_DEPTH cells are full a new
// unique pair is dropped and the sticky overflow flag is set. A finish beat (func 1)
// loads a header beat with own_id into the output register, then the chain shifts down
// toward cell 0 one entry per result beat, so a finish with n entries gives n + 1
// result beats. The final beat carries last, after which the set and the overflow flag
// are empty again. While idle, inserts are taken even if a result beat still waits in
// the output register; a finish waits until that register is free or being taken.
`include "assert_macros.svh"

module sorted_dedup_signature_builder #(
   parameter int SIG_DEPTH = sdsb_pkg::SIG_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdsb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdsb_pkg::rsp_type rsp_data
);

   localparam int CntW = $clog2(SIG_DEPTH + 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(SIG_DEPTH);
   localparam logic [CntW-1:0] OneCnt  = CntW'(1);

   // control state
   sdsb_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // output payload register
   sdsb_pkg::rsp_type   rsp_ff, rsp_in;

   // chain wiring
   sdsb_pkg::pair_type     new_pair;
   sdsb_pkg::pair_type     cell_pair [SIG_DEPTH];
   logic [SIG_DEPTH-1:0]   cell_lt;
   logic [SIG_DEPTH-1:0]   cell_eq;
   logic [SIG_DEPTH-1:0]   cell_valid;
   sdsb_pkg::cell_ctrl_type cell_ctrl;

   logic req_fire;
   logic ins_fire;
   logic fin_fire;
   logic dup_hit;
   logic set_full;
   logic slot_free;
   logic drain_load;

   assign new_pair.label = req_data.edge_label;
   assign new_pair.id    = req_data.dest_id;

   // output slot can take a new beat this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // a finish needs the output slot, an insert does not
   assign req_ready = (state_ff == sdsb_pkg::ST_IDLE) &&
                      (slot_free || (req_data.func == sdsb_pkg::FUNC_INSERT));
   assign req_fire  = req_valid && req_ready;
   assign ins_fire  = req_fire && (req_data.func == sdsb_pkg::FUNC_INSERT);
   assign fin_fire  = req_fire && (req_data.func == sdsb_pkg::FUNC_FINISH);

   assign dup_hit  = |cell_eq;
   assign set_full = (count_ff == FullCnt);

   // cells below the fill count hold live entries
   genvar gi;
   generate
      for (gi = 0; gi < SIG_DEPTH; gi++) begin : g_cell
         sdsb_pkg::pair_type left_pair;
         sdsb_pkg::pair_type right_pair;
         logic               left_lt;

         assign cell_valid[gi] = (count_ff > CntW'(gi));

         if (gi == 0) begin : g_first
            // nothing below cell 0: it takes the new pair whenever it is not smaller
            assign left_pair = new_pair;
            assign left_lt   = 1'b1;
         end else begin : g_inner
            assign left_pair = cell_pair[gi-1];
            assign left_lt   = cell_lt[gi-1];
         end

         if (gi == SIG_DEPTH - 1) begin : g_top
            // top cell has no upper neighbor; what it takes on a shift is past the count
            assign right_pair = new_pair;
         end else begin : g_below
            assign right_pair = cell_pair[gi+1];
         end

         sdsb_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .valid      (cell_valid[gi]),
            .new_pair   (new_pair),
            .left_pair  (left_pair),
            .left_lt    (left_lt),
            .right_pair (right_pair),
            .pair       (cell_pair[gi]),
            .lt         (cell_lt[gi]),
            .eq         (cell_eq[gi])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdsb_pkg::ST_IDLE: begin
            if (fin_fire && (count_ff != '0)) begin
               state_in = sdsb_pkg::ST_DRAIN;
            end
         end
         sdsb_pkg::ST_DRAIN: begin
            if (slot_free && (count_ff == OneCnt)) begin
               state_in = sdsb_pkg::ST_IDLE;
            end
         end
         default: state_in = sdsb_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      drain_load       = 1'b0;
      cell_ctrl.insert = 1'b0;
      cell_ctrl.shift  = 1'b0;
      case (state_ff)
         sdsb_pkg::ST_IDLE: begin
            cell_ctrl.insert = ins_fire && !dup_hit && !set_full;
         end
         sdsb_pkg::ST_DRAIN: begin
            drain_load      = slot_free;
            cell_ctrl.shift = slot_free;
         end
         default: begin
            drain_load = 1'b0;
         end
      endcase
   end

   // fill count and sticky overflow
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cell_ctrl.insert) begin
         count_in = count_ff + OneCnt;
      end else if (drain_load) begin
         count_in = count_ff - OneCnt;
      end
      if (ins_fire && !dup_hit && set_full) begin
         overflow_in = 1'b1;
      end
      // the flag lives until the last beat of the run is loaded
      if ((fin_fire && (count_ff == '0)) || (drain_load && (count_ff == OneCnt))) begin
         overflow_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (fin_fire) begin
         rsp_valid_in     = 1'b1;
         rsp_in.kind      = sdsb_pkg::KIND_HEADER;
         rsp_in.out_label = '0;
         rsp_in.out_id    = req_data.own_id;
         rsp_in.overflow  = overflow_ff;
         rsp_in.last      = (count_ff == '0);
      end else if (drain_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.kind      = sdsb_pkg::KIND_ENTRY;
         rsp_in.out_label = cell_pair[0].label;
         rsp_in.out_id    = cell_pair[0].id;
         rsp_in.overflow  = overflow_ff;
         rsp_in.last      = (count_ff == OneCnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdsb_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fill count never passes the chain length
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FullCnt, "fill count above depth")

   // draining always has an entry left to send
   `ASSERT_CLK(a_drain_nonempty, clock, reset, (state_ff == sdsb_pkg::ST_DRAIN) |-> (count_ff != '0), "drain with empty set")

   // overflow only comes up while the set is full
   `ASSERT_CLK(a_overflow_full, clock, reset, $rose(overflow_ff) |-> ($past(count_ff) == FullCnt), "overflow without full set")

   // a beat waiting while idle must be the end of its run
   `ASSERT_CLK(a_idle_last, clock, reset, (rsp_valid_ff && (state_ff == sdsb_pkg::ST_IDLE)) |-> rsp_ff.last, "non-final beat left while idle")

   // a finish with entries starts a drain
   `ASSERT_CLK(a_finish_drain, clock, reset, (fin_fire && (count_ff != '0)) |=> (state_ff == sdsb_pkg::ST_DRAIN), "finish did not start drain")

endmodule
